### hw/rtl/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg: terminal escape key decoder package
// Beat types, key numbers, character codes and key lookup functions.
// ----------------------------------------------------------------------------
package tekd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_special;
    logic [7:0] code;
    logic       ctrl_modifier;
  } out_item_t;

  // event kinds
  localparam logic KindByte    = 1'b0;
  localparam logic KindTimeout = 1'b1;

  // characters
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLbrk  = 8'h5B;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig1  = 8'h31;
  localparam logic [7:0] ChDig2  = 8'h32;
  localparam logic [7:0] ChDig9  = 8'h39;

  // key numbers
  localparam logic [7:0] KeyUp    = 8'd0;
  localparam logic [7:0] KeyDown  = 8'd1;
  localparam logic [7:0] KeyRight = 8'd2;
  localparam logic [7:0] KeyLeft  = 8'd3;
  localparam logic [7:0] KeyHome  = 8'd4;
  localparam logic [7:0] KeyEnd   = 8'd5;
  localparam logic [7:0] KeyIns   = 8'd6;
  localparam logic [7:0] KeyDel   = 8'd7;
  localparam logic [7:0] KeyPgUp  = 8'd8;
  localparam logic [7:0] KeyPgDn  = 8'd9;
  localparam logic [7:0] KeyF1    = 8'd10;
  localparam logic [7:0] KeyF2    = 8'd11;
  localparam logic [7:0] KeyF3    = 8'd12;
  localparam logic [7:0] KeyF4    = 8'd13;
  localparam logic [7:0] KeyF5    = 8'd14;
  localparam logic [7:0] KeyF6    = 8'd15;
  localparam logic [7:0] KeyF7    = 8'd16;
  localparam logic [7:0] KeyF8    = 8'd17;
  localparam logic [7:0] KeyF9    = 8'd18;
  localparam logic [7:0] KeyF10   = 8'd19;
  localparam logic [7:0] KeyF11   = 8'd20;
  localparam logic [7:0] KeyF12   = 8'd21;
  localparam logic [7:0] KeyNone  = 8'hFF;

  function automatic logic [7:0] csi_letter(input logic [7:0] b);
    case (b)
      8'h41:   return KeyUp;
      8'h42:   return KeyDown;
      8'h43:   return KeyRight;
      8'h44:   return KeyLeft;
      8'h46:   return KeyEnd;
      8'h48:   return KeyHome;
      default: return KeyNone;
    endcase
  endfunction

  function automatic logic [7:0] ss3_letter(input logic [7:0] b);
    case (b)
      8'h48:   return KeyHome;
      8'h46:   return KeyEnd;
      8'h50:   return KeyF1;
      8'h51:   return KeyF2;
      8'h52:   return KeyF3;
      8'h53:   return KeyF4;
      default: return KeyNone;
    endcase
  endfunction

  function automatic logic [7:0] mod_letter(input logic [7:0] b);
    case (b)
      8'h41:   return KeyUp;
      8'h42:   return KeyDown;
      8'h43:   return KeyRight;
      8'h44:   return KeyLeft;
      8'h50:   return KeyF1;
      8'h51:   return KeyF2;
      8'h52:   return KeyF3;
      8'h53:   return KeyF4;
      default: return KeyNone;
    endcase
  endfunction

  function automatic logic [7:0] tilde_key(input logic [7:0] d);
    case (d)
      8'h31:   return KeyHome;
      8'h32:   return KeyIns;
      8'h33:   return KeyDel;
      8'h34:   return KeyEnd;
      8'h35:   return KeyPgUp;
      8'h36:   return KeyPgDn;
      8'h37:   return KeyHome;
      8'h38:   return KeyEnd;
      default: return KeyNone;
    endcase
  endfunction

  // xterm two-digit function key numbers
  function automatic logic [7:0] fkey(input logic [7:0] d1, input logic [7:0] d2);
    case ({d1, d2})
      {ChDig1, 8'h35}: return KeyF5;
      {ChDig1, 8'h37}: return KeyF6;
      {ChDig1, 8'h38}: return KeyF7;
      {ChDig1, 8'h39}: return KeyF8;
      {ChDig2, 8'h30}: return KeyF9;
      {ChDig2, 8'h31}: return KeyF10;
      {ChDig2, 8'h33}: return KeyF11;
      {ChDig2, 8'h34}: return KeyF12;
      default:         return KeyNone;
    endcase
  endfunction

  function automatic out_item_t key_or_esc(input logic [7:0] key, input logic ctrl);
    out_item_t r;
    r.ctrl_modifier = ctrl;
    if (key == KeyNone) begin
      r.is_special = 1'b0;
      r.code       = ChEsc;
    end else begin
      r.is_special = 1'b1;
      r.code       = key;
    end
    return r;
  endfunction

endpackage

### hw/rtl/tekd_intf.sv
// ----------------------------------------------------------------------------
// tekd channel interfaces
// Valid/ready channels for input events and decoded keys.
// ----------------------------------------------------------------------------
interface tekd_in_if;
  import tekd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tekd_out_if;
  import tekd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Decodes vt100/xterm escape sequences from a terminal byte stream into keys.
// ----------------------------------------------------------------------------
// the input register holds a taken beat; its result then goes to the result register
// throughput: one input beat per cycle while the result side keeps up
// both stages are plain registers; the parser state advances when the input stage moves on
// reset: parser idle, parameters and ctrl flag zero, no beats held
module terminal_escape_key_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  tekd_in_if.sink     in_i,
  tekd_out_if.source  out_o
);
  import tekd_pkg::*;

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhEsc      = 4'd1;
  localparam logic [3:0] PhCsi      = 4'd2;
  localparam logic [3:0] PhSs3      = 4'd3;
  localparam logic [3:0] PhJunk     = 4'd4;
  localparam logic [3:0] PhCsiDig   = 4'd5;
  localparam logic [3:0] PhModSkip  = 4'd6;
  localparam logic [3:0] PhModFinal = 4'd7;
  localparam logic [3:0] PhFkAfter  = 4'd8;
  localparam logic [3:0] PhFkMod    = 4'd9;
  localparam logic [3:0] PhFkTail   = 4'd10;

  logic       in_vld_q;
  in_item_t   in_item_q;
  logic       out_vld_q;
  out_item_t  out_item_q;
  logic       adv;

  logic [3:0] phase_q, phase_d, ph;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       ctrl_q, ctrl_d;
  logic       res_vld;
  out_item_t  res;
  logic [7:0] b;
  logic [7:0] k;

  // input stage moves on when the result slot is free or being emptied
  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_item_q;

  assign b = in_item_q.in_byte;
  assign ph = (phase_q > PhFkTail) ? PhIdle : phase_q;

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    ctrl_d   = ctrl_q;
    res_vld  = 1'b0;
    res      = key_or_esc(KeyNone, ctrl_q);
    k        = KeyNone;
    if (ph == PhIdle) begin
      phase_d = PhIdle;
      if (in_item_q.kind == KindByte) begin
        ctrl_d = 1'b0;
        if (b == ChEsc) begin
          phase_d = PhEsc;
        end else begin
          res_vld           = 1'b1;
          res.is_special    = 1'b0;
          res.code          = (b == ChDel) ? ChBs : b;
          res.ctrl_modifier = 1'b0;
        end
      end
    end else if (in_item_q.kind == KindTimeout) begin
      res_vld = 1'b1;
      res     = key_or_esc(KeyNone, ctrl_q);
    end else begin
      case (ph)
        PhEsc: begin
          phase_d = (b == ChLbrk) ? PhCsi : (b == ChO) ? PhSs3 : PhJunk;
        end
        PhJunk: begin
          res_vld = 1'b1;
          res     = key_or_esc(KeyNone, ctrl_q);
        end
        PhSs3: begin
          res_vld = 1'b1;
          res     = key_or_esc(ss3_letter(b), ctrl_q);
        end
        PhCsi: begin
          if (b >= ChDig0 && b <= ChDig9) begin
            first_d = b;
            phase_d = PhCsiDig;
          end else if (b == ChE) begin
            res_vld           = 1'b1;
            res.is_special    = 1'b0;
            res.code          = ChNul;
            res.ctrl_modifier = ctrl_q;
          end else begin
            res_vld = 1'b1;
            res     = key_or_esc(csi_letter(b), ctrl_q);
          end
        end
        PhCsiDig: begin
          if (b == ChTilde) begin
            res_vld = 1'b1;
            res     = key_or_esc(tilde_key(first_q), ctrl_q);
          end else if (b == ChSemi) begin
            phase_d = PhModSkip;
          end else if (first_q == ChDig1 || first_q == ChDig2) begin
            second_d = b;
            phase_d  = PhFkAfter;
          end else begin
            res_vld = 1'b1;
            res     = key_or_esc(KeyNone, ctrl_q);
          end
        end
        PhModSkip: begin
          phase_d = PhModFinal;
        end
        PhModFinal: begin
          k = mod_letter(b);
          if (k != KeyNone) begin
            ctrl_d = 1'b1;
          end
          res_vld = 1'b1;
          res     = key_or_esc(k, ctrl_d);
        end
        PhFkAfter: begin
          if (b == ChTilde) begin
            res_vld = 1'b1;
            res     = key_or_esc(fkey(first_q, second_q), ctrl_q);
          end else begin
            phase_d = (b == ChSemi) ? PhFkMod : PhFkTail;
          end
        end
        PhFkMod: begin
          ctrl_d = 1'b1;
          if (b == ChTilde) begin
            res_vld = 1'b1;
            res     = key_or_esc(fkey(first_q, second_q), 1'b1);
          end else begin
            phase_d = PhFkTail;
          end
        end
        default: begin
          // trailing byte after the modifier, or after a non-tilde byte past the two digits
          ctrl_d  = 1'b1;
          res_vld = 1'b1;
          res     = key_or_esc(fkey(first_q, second_q), 1'b1);
        end
      endcase
    end
    if (res_vld) begin
      phase_d = PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PhIdle;
      first_q   <= 8'd0;
      second_q  <= 8'd0;
      ctrl_q    <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= res_vld;
        phase_q   <= phase_d;
        first_q   <= first_d;
        second_q  <= second_d;
        ctrl_q    <= ctrl_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
    if (adv && res_vld) begin
      out_item_q <= res;
    end
  end

endmodule

### tb/tekd_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tekd_tb_pkg: key decode scoreboard
// Tracks the escape sequence parser state for every event taken by the
// decoder and checks each decoded key beat against the oldest expected one.
// ----------------------------------------------------------------------------
package tekd_tb_pkg;
  import tekd_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhEsc, PhCsi, PhSs3, PhJunk, PhCsiDig,
    PhModSkip, PhModFinal, PhFkAfter, PhFkMod, PhFkTail
  } parse_phase_e;

  class key_decode_sb;
    parse_phase_e phase;
    logic [7:0]   digit_a;
    logic [7:0]   digit_b;
    logic         ctrl_flag;
    out_item_t    expected_keys[$];
    int           errors;

    function new();
      phase     = PhIdle;
      digit_a   = '0;
      digit_b   = '0;
      ctrl_flag = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction

    function logic [7:0] csi_final_key(logic [7:0] b);
      case (b)
        "A":     return KeyUp;
        "B":     return KeyDown;
        "C":     return KeyRight;
        "D":     return KeyLeft;
        "F":     return KeyEnd;
        "H":     return KeyHome;
        default: return KeyNone;
      endcase
    endfunction

    function logic [7:0] ss3_final_key(logic [7:0] b);
      case (b)
        "H":     return KeyHome;
        "F":     return KeyEnd;
        "P":     return KeyF1;
        "Q":     return KeyF2;
        "R":     return KeyF3;
        "S":     return KeyF4;
        default: return KeyNone;
      endcase
    endfunction

    function logic [7:0] mod_final_key(logic [7:0] b);
      case (b)
        "A":     return KeyUp;
        "B":     return KeyDown;
        "C":     return KeyRight;
        "D":     return KeyLeft;
        "P":     return KeyF1;
        "Q":     return KeyF2;
        "R":     return KeyF3;
        "S":     return KeyF4;
        default: return KeyNone;
      endcase
    endfunction

    function logic [7:0] digit_tilde_key(logic [7:0] d);
      case (d)
        "1", "7": return KeyHome;
        "2":      return KeyIns;
        "3":      return KeyDel;
        "4", "8": return KeyEnd;
        "5":      return KeyPgUp;
        "6":      return KeyPgDn;
        default:  return KeyNone;
      endcase
    endfunction

    // xterm numbering skips 16 and 22
    function logic [7:0] two_digit_fkey(logic [7:0] d1, logic [7:0] d2);
      if (d1 == ChDig1) begin
        case (d2)
          "5":     return KeyF5;
          "7":     return KeyF6;
          "8":     return KeyF7;
          "9":     return KeyF8;
          default: return KeyNone;
        endcase
      end else if (d1 == ChDig2) begin
        case (d2)
          "0":     return KeyF9;
          "1":     return KeyF10;
          "3":     return KeyF11;
          "4":     return KeyF12;
          default: return KeyNone;
        endcase
      end
      return KeyNone;
    endfunction

    // ends the sequence: key number, or plain esc when nothing matched
    function out_item_t close_seq(logic [7:0] key);
      out_item_t r;
      phase           = PhIdle;
      r.ctrl_modifier = ctrl_flag;
      if (key == KeyNone) begin
        r.is_special = 1'b0;
        r.code       = ChEsc;
      end else begin
        r.is_special = 1'b1;
        r.code       = key;
      end
      return r;
    endfunction

    function bit decode_event(in_item_t it, output out_item_t r);
      logic [7:0] b;
      logic [7:0] k;
      b = it.in_byte;
      r = '0;
      if (phase == PhIdle) begin
        if (it.kind == KindTimeout) return 1'b0;
        ctrl_flag = 1'b0;
        if (b == ChEsc) begin
          phase = PhEsc;
          return 1'b0;
        end
        r.code = (b == ChDel) ? ChBs : b;
        return 1'b1;
      end
      if (it.kind == KindTimeout) begin
        r = close_seq(KeyNone);
        return 1'b1;
      end
      case (phase)
        PhEsc: begin
          if (b == ChLbrk) phase = PhCsi;
          else if (b == ChO) phase = PhSs3;
          else phase = PhJunk;
          return 1'b0;
        end
        PhJunk: r = close_seq(KeyNone);
        PhSs3: r = close_seq(ss3_final_key(b));
        PhCsi: begin
          if (b >= ChDig0 && b <= ChDig9) begin
            digit_a = b;
            phase   = PhCsiDig;
            return 1'b0;
          end
          if (b == ChE) begin
            r      = close_seq(KeyNone);
            r.code = ChNul;
          end else begin
            r = close_seq(csi_final_key(b));
          end
        end
        PhCsiDig: begin
          if (b == ChTilde) begin
            r = close_seq(digit_tilde_key(digit_a));
          end else if (b == ChSemi) begin
            phase = PhModSkip;
            return 1'b0;
          end else if (digit_a == ChDig1 || digit_a == ChDig2) begin
            digit_b = b;
            phase   = PhFkAfter;
            return 1'b0;
          end else begin
            r = close_seq(KeyNone);
          end
        end
        PhModSkip: begin
          // modifier value itself is ignored
          phase = PhModFinal;
          return 1'b0;
        end
        PhModFinal: begin
          k = mod_final_key(b);
          if (k != KeyNone) ctrl_flag = 1'b1;
          r = close_seq(k);
        end
        PhFkAfter: begin
          if (b == ChTilde) begin
            r = close_seq(two_digit_fkey(digit_a, digit_b));
          end else begin
            if (b == ChSemi) phase = PhFkMod;
            else phase = PhFkTail;
            return 1'b0;
          end
        end
        PhFkMod: begin
          ctrl_flag = 1'b1;
          if (b == ChTilde) begin
            r = close_seq(two_digit_fkey(digit_a, digit_b));
          end else begin
            phase = PhFkTail;
            return 1'b0;
          end
        end
        default: begin
          ctrl_flag = 1'b1;
          r = close_seq(two_digit_fkey(digit_a, digit_b));
        end
      endcase
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      if (decode_event(it, r)) expected_keys.push_back(r);
    endfunction

    function void field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_key(out_item_t act);
      out_item_t exp_k;
      if (expected_keys.size() == 0) begin
        errors++;
        $display("%0t: unexpected key beat, expected none actual %0h", $time, act);
        return;
      end
      exp_k = expected_keys.pop_front();
      field_check("is_special", 8'(exp_k.is_special), 8'(act.is_special));
      field_check("code", exp_k.code, act.code);
      field_check("ctrl_modifier", 8'(exp_k.ctrl_modifier), 8'(act.ctrl_modifier));
    endfunction
  endclass

endpackage

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: terminal_escape_key_decoder
// Feeds terminal bytes and read timeouts, mostly as escape sequences with
// random content plus noise and cut-off sequences, under random sender gaps
// and receiver stalls, and checks every decoded key against a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import tekd_pkg::*;
  import tekd_tb_pkg::*;

  localparam int RandomItems = 1250;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;

  typedef enum int {
    SqPlain, SqTimeout, SqCsi, SqSs3, SqTilde, SqMod, SqFkey, SqJunk
  } seq_kind_e;

  typedef enum int {RxFree, RxCoin, RxMostly, RxBursty} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  tekd_in_if  in_if ();
  tekd_out_if out_if ();

  terminal_escape_key_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  key_decode_sb sb;
  in_item_t     seq_q[$];
  int           items_sent = 0;
  int           burst_left = 0;
  int           cycles     = 0;
  rx_mode_e     rx_mode    = RxFree;
  int           rx_left    = 0;
  int           rx_stall   = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // beats are taken at the rising edge, before any register updates land
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_input(in_if.payload);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_key(out_if.payload);
  end

  // receiver back-pressure, switching between patterns
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, RxBursty));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RxFree:   out_if.ready = 1'b1;
      RxCoin:   out_if.ready = $urandom_range(0, 1);
      RxMostly: out_if.ready = ($urandom_range(0, 7) != 0);
      default: begin
        if (rx_stall > 0) begin
          out_if.ready = 1'b0;
          rx_stall--;
        end else begin
          out_if.ready = 1'b1;
          if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 12);
        end
      end
    endcase
  end

  function automatic in_item_t byte_beat(logic [7:0] b);
    in_item_t it;
    it.kind    = KindByte;
    it.in_byte = b;
    return it;
  endfunction

  function automatic in_item_t tmo_beat();
    in_item_t it;
    it.kind    = KindTimeout;
    it.in_byte = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic logic [7:0] any_byte();
    return $urandom_range(0, 255);
  endfunction

  // mostly a byte from the pool, sometimes anything
  function automatic logic [7:0] pick(string pool);
    if ($urandom_range(0, 4) == 0) return any_byte();
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid   = 1'b0;
        in_if.payload = {1'($urandom_range(0, 1)), any_byte()};
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid   = 1'b1;
    in_if.payload = it;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_queue();
    foreach (seq_q[i]) send_beat(seq_q[i]);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic build_sequence();
    seq_kind_e  kind;
    int         cut;
    logic [7:0] d1;
    kind  = seq_kind_e'($urandom_range(0, SqJunk));
    seq_q = {};
    case (kind)
      SqPlain: seq_q.push_back(byte_beat(($urandom_range(0, 5) == 0) ? ChDel : any_byte()));
      SqTimeout: seq_q.push_back(tmo_beat());
      SqCsi: seq_q = {byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(pick("ABCDFHE"))};
      SqSs3: seq_q = {byte_beat(ChEsc), byte_beat(ChO), byte_beat(pick("HFPQRS"))};
      SqTilde: begin
        seq_q = {byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(pick("0123456789")),
                 byte_beat(pick("~"))};
      end
      SqMod: begin
        seq_q = {byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(pick("123456")),
                 byte_beat(ChSemi), byte_beat(any_byte()), byte_beat(pick("ABCDPQRS"))};
      end
      SqFkey: begin
        d1    = pick("12");
        seq_q = {byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(d1),
                 byte_beat((d1 == ChDig1) ? pick("5789") : pick("0134"))};
        if ($urandom_range(0, 3) == 0) seq_q[3] = byte_beat(pick("0123456789"));
        case ($urandom_range(0, 3))
          0: seq_q.push_back(byte_beat(ChTilde));
          1: seq_q = {seq_q, byte_beat(ChSemi), byte_beat(pick("2345678")),
                      byte_beat(ChTilde)};
          2: seq_q = {seq_q, byte_beat(ChSemi), byte_beat(any_byte()),
                      byte_beat(any_byte())};
          default: seq_q = {seq_q, byte_beat(pick("xA5")), byte_beat(any_byte())};
        endcase
      end
      default: seq_q = {byte_beat(ChEsc), byte_beat(any_byte()), byte_beat(any_byte())};
    endcase
    // broken sequences: cut short by a timeout, or one byte garbled
    if (seq_q.size() > 1) begin
      case ($urandom_range(0, 9))
        0: begin
          cut   = $urandom_range(1, seq_q.size() - 1);
          seq_q = seq_q[0:cut-1];
          seq_q.push_back(tmo_beat());
        end
        1: seq_q[$urandom_range(1, seq_q.size() - 1)] = byte_beat(any_byte());
        default: ;
      endcase
    end
  endtask

  initial begin
    int  directed_count;
    bit  paused;
    sb            = new();
    paused        = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, csi, ss3, modified function key, modifier and csi E sequences,
    // timeouts idle and mid-sequence, unknown introducer, esc inside a sequence
    seq_q = {byte_beat(ChNul), byte_beat(8'hFF), byte_beat(ChDel), tmo_beat(),
             byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat("A"),
             byte_beat(ChEsc), byte_beat(ChO), byte_beat("P"),
             byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(ChDig1), byte_beat("5"),
             byte_beat(ChSemi), byte_beat("5"), byte_beat(ChTilde),
             byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(ChDig1), byte_beat(ChSemi),
             byte_beat("5"), byte_beat("C"),
             byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(ChE),
             byte_beat(ChEsc), tmo_beat(),
             byte_beat(ChEsc), byte_beat("x"), byte_beat("y"),
             byte_beat(ChEsc), byte_beat(ChLbrk), byte_beat(ChEsc)};
    send_queue();
    directed_count = items_sent;
    wait_drained();

    while (items_sent < directed_count + RandomItems) begin
      if (!paused && items_sent > directed_count + RandomItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      build_sequence();
      send_queue();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
